FILE: sv/dwpm_pkg.sv
// Shared types and constants for the decimating window power meter.
// Used by the front, back and top modules; depends on nothing.
package dwpm_pkg;

  // Sample and accumulator widths fixed by the payload
  localparam int SAMPLE_BITS = 16;
  localparam int SUM_BITS    = 55;
  localparam int POWER_BITS  = 11;

  // Default counter width for the top-level parameter
  localparam int COUNT_BITS_DEFAULT = 24;

  // Job queue depth between front and back
  localparam int JOB_DEPTH = 2;

  // Register reset values
  localparam int DECIM_RESET  = 4;
  localparam int WINDOW_RESET = 691200;
  localparam int AVG_RESET    = 180000;

  // Register indexes
  localparam logic [1:0] REG_DECIM  = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_AVG    = 2'd2;

  // Decimation limits
  localparam logic [4:0] DECIM_MAX = 5'd16;

  // 100*log10(2) in Q16, silent code, output limits
  localparam logic signed [22:0] DB_PER_LOG2_Q16 = 23'sd1972830;
  localparam logic signed [POWER_BITS-1:0] SILENT_DB = -11'sd1000;
  localparam logic signed [15:0] POWER_MAX = 16'sd1023;
  localparam logic signed [15:0] POWER_MIN = -16'sd1024;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start_window;
  } in_t;

  typedef struct packed {
    logic signed [POWER_BITS-1:0] power_tenths_db;
    logic                         silent;
  } out_t;

endpackage

FILE: sv/dwpm_fifo.sv
// Small register queue carrying finished window jobs from front to back.
// Generic width and depth; uses no package items.
module dwpm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign push_ready_o = (count_q != CNT_BITS'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/dwpm_front.sv
// Front end: window tracking, decimation, squaring and saturating accumulation.
// Depends on dwpm_pkg; pushes one job (sum, divisor) per window into the queue.
module dwpm_front #(
  parameter int COUNT_BITS = dwpm_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  dwpm_pkg::in_t          in_data_i,
  output logic                   in_ready_o,
  input  logic [4:0]             decim_i,
  input  logic [COUNT_BITS-1:0]  window_i,
  input  logic [COUNT_BITS-1:0]  avg_i,
  output logic                   push_valid_o,
  output logic [dwpm_pkg::SUM_BITS+COUNT_BITS-1:0] push_data_o,
  input  logic                   push_ready_i
);

  localparam int SB = dwpm_pkg::SAMPLE_BITS;
  localparam int UB = dwpm_pkg::SUM_BITS;

  // Window state
  logic                  cap_q, cap_d;
  logic [3:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] in_cnt_q, in_cnt_d, kept_q, kept_d;
  logic [UB-1:0]         sum_q, sum_d;

  // Square stage
  logic                  stg_valid_q, stg_valid_d;
  logic                  stg_keep_q, stg_clr_q, stg_last_q;
  logic [2*SB-1:0]       stg_sq_q;
  logic [COUNT_BITS-1:0] stg_div_q;

  logic                  accept, stg_stall, stg_fire, live;
  logic [4:0]            factor;
  logic [COUNT_BITS-1:0] win, in_base, kept_base, in_new, kept_new, div_max, div;
  logic [3:0]            phase_base;
  logic                  keep, last;
  logic [SB-1:0]         raw, mag;
  logic [2*SB-1:0]       sq;
  logic [UB-1:0]         base, addend;
  logic [UB:0]           total;
  logic [UB-1:0]         sum_new;

  assign stg_stall  = stg_valid_q && stg_last_q && !push_ready_i;
  assign stg_fire   = stg_valid_q && !stg_stall;
  assign in_ready_o = !stg_stall;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the incoming sample
  always_comb begin
    factor = decim_i;
    if (factor == 5'd0) begin
      factor = 5'd1;
    end else if (factor > dwpm_pkg::DECIM_MAX) begin
      factor = dwpm_pkg::DECIM_MAX;
    end
    win = (window_i == '0) ? COUNT_BITS'(1) : window_i;

    live       = in_data_i.start_window || cap_q;
    phase_base = in_data_i.start_window ? 4'd0 : phase_q;
    in_base    = in_data_i.start_window ? '0 : in_cnt_q;
    kept_base  = in_data_i.start_window ? '0 : kept_q;

    keep     = (phase_base == 4'd0);
    kept_new = kept_base + COUNT_BITS'(keep);
    in_new   = in_base + 1'b1;
    last     = (in_new >= win);

    div_max = (kept_new > avg_i) ? kept_new : avg_i;
    div     = (div_max == '0) ? COUNT_BITS'(1) : div_max;

    raw = in_data_i.sample;
    mag = raw[SB-1] ? (~raw + 1'b1) : raw;
    sq  = mag * mag;

    cap_d    = cap_q;
    phase_d  = phase_q;
    in_cnt_d = in_cnt_q;
    kept_d   = kept_q;
    if (accept && live) begin
      cap_d    = !last;
      phase_d  = ({1'b0, phase_base} + 5'd1 >= factor) ? 4'd0 : phase_base + 4'd1;
      in_cnt_d = in_new;
      kept_d   = kept_new;
    end
  end

  // Accumulate the staged square with saturation
  always_comb begin
    base    = stg_clr_q ? '0 : sum_q;
    addend  = stg_keep_q ? UB'(stg_sq_q) : '0;
    total   = {1'b0, base} + {1'b0, addend};
    sum_new = total[UB] ? '1 : total[UB-1:0];
    sum_d   = stg_fire ? sum_new : sum_q;
  end

  assign push_valid_o = stg_valid_q && stg_last_q;
  assign push_data_o  = {sum_new, stg_div_q};

  // Load the stage when it moves or is empty
  assign stg_valid_d = (stg_valid_q && stg_stall) || (accept && live);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= 1'b0;
      phase_q     <= 4'd0;
      in_cnt_q    <= '0;
      kept_q      <= '0;
      sum_q       <= '0;
      stg_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      phase_q     <= phase_d;
      in_cnt_q    <= in_cnt_d;
      kept_q      <= kept_d;
      sum_q       <= sum_d;
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && live) begin
      stg_keep_q <= keep;
      stg_clr_q  <= in_data_i.start_window;
      stg_last_q <= last;
      stg_sq_q   <= sq;
      stg_div_q  <= div;
    end
  end

endmodule

FILE: sv/dwpm_back.sv
// Back end: fixed-point log2 of sum and divisor, dB scaling, rounding, clamping, output register.
// Depends on dwpm_pkg; pops one job from the queue and delivers one result.
module dwpm_back #(
  parameter int COUNT_BITS = dwpm_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  input  logic [dwpm_pkg::SUM_BITS+COUNT_BITS-1:0] job_data_i,
  output logic                   job_pop_o,
  output logic                   out_valid_o,
  output dwpm_pkg::out_t         out_data_o,
  input  logic                   out_ready_i
);

  localparam int UB = dwpm_pkg::SUM_BITS;
  localparam int EB = $clog2(UB);
  localparam int LB = EB + 16;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NORM = 3'd1;
  localparam logic [2:0] ST_SQR  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_RND  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]            state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  op_q;
  logic [UB-1:0]         x_q;
  logic [EB-1:0]         e_q;
  logic [30:0]           m_q;
  logic [61:0]           prod_q;
  logic [15:0]           frac_q;
  logic [3:0]            bit_q;
  logic [COUNT_BITS-1:0] div_q;
  logic [LB-1:0]         lsum_q;
  logic signed [LB:0]    d_q;
  logic signed [47:0]    p_q;
  dwpm_pkg::out_t        res_q, out_q;

  logic [UB-1:0]         job_sum;
  logic [COUNT_BITS-1:0] job_div;
  logic [31:0]           sq;
  logic [15:0]           frac_n;
  logic [LB-1:0]         lval;
  logic signed [47:0]    rnd;
  logic signed [15:0]    t;
  logic                  load_out;

  assign job_sum = job_data_i[UB+COUNT_BITS-1:COUNT_BITS];
  assign job_div = job_data_i[COUNT_BITS-1:0];
  assign sq      = prod_q[61:30];
  assign frac_n  = {frac_q[14:0], sq[31]};
  assign lval    = {e_q, frac_n};
  assign rnd     = p_q + 48'sd2147483648;
  assign t       = rnd[47:32];

  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;
  assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Sequence the log unit
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = (job_sum == '0) ? ST_DONE : ST_NORM;
        end
      end
      ST_NORM: begin
        if (x_q[UB-1]) begin
          state_d = ST_SQR;
        end
      end
      ST_SQR: state_d = ST_UPD;
      ST_UPD: begin
        if (bit_q == 4'd15) begin
          state_d = op_q ? ST_MUL : ST_NORM;
        end else begin
          state_d = ST_SQR;
        end
      end
      ST_MUL:  state_d = ST_RND;
      ST_RND:  state_d = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result until the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath of the log unit
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        op_q  <= 1'b0;
        x_q   <= job_sum;
        e_q   <= EB'(UB - 1);
        div_q <= job_div;
        res_q <= '{power_tenths_db: dwpm_pkg::SILENT_DB, silent: 1'b1};
      end
      ST_NORM: begin
        if (x_q[UB-1]) begin
          m_q    <= x_q[UB-1 -: 31];
          frac_q <= '0;
          bit_q  <= 4'd0;
        end else begin
          x_q <= {x_q[UB-2:0], 1'b0};
          e_q <= e_q - 1'b1;
        end
      end
      ST_SQR: prod_q <= m_q * m_q;
      ST_UPD: begin
        m_q    <= sq[31] ? sq[31:1] : sq[30:0];
        frac_q <= frac_n;
        bit_q  <= bit_q + 1'b1;
        if (bit_q == 4'd15) begin
          if (op_q) begin
            d_q <= $signed({1'b0, lsum_q}) - $signed({1'b0, lval});
          end else begin
            lsum_q <= lval;
            op_q   <= 1'b1;
            x_q    <= UB'(div_q);
            e_q    <= EB'(UB - 1);
          end
        end
      end
      ST_MUL: p_q <= 48'(d_q) * 48'(dwpm_pkg::DB_PER_LOG2_Q16);
      ST_RND: begin
        res_q.silent <= 1'b0;
        if (t > dwpm_pkg::POWER_MAX) begin
          res_q.power_tenths_db <= dwpm_pkg::POWER_MAX[dwpm_pkg::POWER_BITS-1:0];
        end else if (t < dwpm_pkg::POWER_MIN) begin
          res_q.power_tenths_db <= dwpm_pkg::POWER_MIN[dwpm_pkg::POWER_BITS-1:0];
        end else begin
          res_q.power_tenths_db <= t[dwpm_pkg::POWER_BITS-1:0];
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/decimating_window_power_meter_db.sv
// Decimating window power meter: takes one audio sample per clock cycle
// while the input is not stalled, and within a capture window squares
// and accumulates every decimation-th sample. At the end of each window it
// gives one result, 10*log10(sum / max(kept, average_length)) in tenths of
// dB. The delay of the result after the window's last sample is set by the
// one-bit-a-cycle normalizing shifter and the squaring step (ST_SQR, then
// ST_UPD) of the shared log2 unit, which runs once for the sum and once
// for the divisor; a silent window (zero sum) skips the log unit.
// Up to two finished windows queue ahead of the log unit; input stalls only
// when that queue is full. Registers sit on an APB port at 0x0, 0x4, 0x8.
module decimating_window_power_meter_db #(
  parameter int COUNT_BITS = dwpm_pkg::COUNT_BITS_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  dwpm_pkg::in_t  in_data_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output dwpm_pkg::out_t out_data_o,
  input  logic           out_ready_i,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int JOB_BITS = dwpm_pkg::SUM_BITS + COUNT_BITS;

  logic [4:0]            decim_q;
  logic [COUNT_BITS-1:0] window_q, avg_q;
  logic                  wr_en;
  logic                  push_valid, push_ready, job_valid, job_pop;
  logic [JOB_BITS-1:0]   push_data, job_data;

  // Register file
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q  <= 5'(dwpm_pkg::DECIM_RESET);
      window_q <= COUNT_BITS'(dwpm_pkg::WINDOW_RESET);
      avg_q    <= COUNT_BITS'(dwpm_pkg::AVG_RESET);
    end else if (wr_en) begin
      case (paddr[3:2])
        dwpm_pkg::REG_DECIM:  decim_q  <= pwdata[4:0];
        dwpm_pkg::REG_WINDOW: window_q <= pwdata[COUNT_BITS-1:0];
        dwpm_pkg::REG_AVG:    avg_q    <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dwpm_pkg::REG_DECIM:  prdata = 32'(decim_q);
      dwpm_pkg::REG_WINDOW: prdata = 32'(window_q);
      dwpm_pkg::REG_AVG:    prdata = 32'(avg_q);
      default:              prdata = '0;
    endcase
  end

  dwpm_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready_o),
    .decim_i     (decim_q),
    .window_i    (window_q),
    .avg_i       (avg_q),
    .push_valid_o(push_valid),
    .push_data_o (push_data),
    .push_ready_i(push_ready)
  );

  dwpm_fifo #(
    .WIDTH(JOB_BITS),
    .DEPTH(dwpm_pkg::JOB_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_data_i (push_data),
    .push_ready_o(push_ready),
    .pop_i       (job_pop),
    .pop_valid_o (job_valid),
    .pop_data_o  (job_data)
  );

  dwpm_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_data_i (job_data),
    .job_pop_o  (job_pop),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_ready_i(out_ready_i)
  );

endmodule
